/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// Each macro expects clk and arst_n to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle whenever ante holds.
`define AST_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante holds.
`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/esbcd_pkg.sv */
package esbcd_pkg;

	localparam int unsigned SECS_W   = 32;
	localparam int unsigned DAYS_W   = 16;
	localparam int unsigned YEAR_W   = 12;
	localparam int unsigned CNT_W    = 1;

	localparam logic [SECS_W-1:0] DAY_SECS  = 32'd86400;
	localparam logic [SECS_W-1:0] HOUR_SECS = 32'd3600;
	localparam logic [SECS_W-1:0] MIN_SECS  = 32'd60;

	// quotient = (x * RECIP) >> shift, exact over the reachable range of x
	//   days:    x = count >> 7 (25 bits), divide by 675, shift 35
	//   hours:   x = rest >> 4 (13 bits), divide by 225, shift 21
	//   minutes: x = rest >> 2 (10 bits), divide by 15, shift 14
	// constants are sized to the product; the useful widths are 26, 14 and 11 bits
	localparam logic [50:0] DAY_RECIP  = 51'd50903317;
	localparam logic [25:0] HOUR_RECIP = 26'd9321;
	localparam logic [19:0] MIN_RECIP  = 20'd1093;

	// two steps per split pass: quotient, then multiply back and subtract
	localparam logic [CNT_W-1:0] STEP_QUO  = 1'b1;
	localparam logic [CNT_W-1:0] STEP_BACK = 1'b0;

	localparam logic [YEAR_W-1:0] CENTURY_YEAR = 12'd2100;
	localparam logic [3:0]        LAST_MONTH   = 4'd12;
	localparam logic [3:0]        FEB          = 4'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DAY,
		ST_HOUR,
		ST_MIN,
		ST_YEAR,
		ST_MONTH,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_DAY,
		CMD_HOUR,
		CMD_MIN,
		CMD_YEAR,
		CMD_MONTH,
		CMD_PUBLISH
	} cmd_t;

	typedef struct packed {
		logic last_step;
		logic year_end;
		logic month_end;
		logic out_busy;
	} status_t;

	// days in a month of a common year
	function automatic logic [4:0] month_days(input logic [3:0] m);
		logic [4:0] d;
		case (m)
			4'd2:    d = 5'd28;
			4'd4:    d = 5'd30;
			4'd6:    d = 5'd30;
			4'd9:    d = 5'd30;
			4'd11:   d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

	// binary 0..99 to packed BCD
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [3:0] tens;
		logic [6:0] ones;
		tens = 4'd0;
		for (int i = 1; i < 10; i++) begin
			if (v >= 7'(10 * i))
				tens = 4'(i);
		end
		ones = v - 7'(tens) * 7'd10;
		return {tens, ones[3:0]};
	endfunction

endpackage

/* rtl/esbcd_ctrl.sv */
module esbcd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  esbcd_pkg::status_t status,
	output esbcd_pkg::cmd_t    cmd
);

	esbcd_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= esbcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			esbcd_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = esbcd_pkg::ST_DAY;
			end
			esbcd_pkg::ST_DAY: begin
				if (status.last_step)
					state_d = esbcd_pkg::ST_HOUR;
			end
			esbcd_pkg::ST_HOUR: begin
				if (status.last_step)
					state_d = esbcd_pkg::ST_MIN;
			end
			esbcd_pkg::ST_MIN: begin
				if (status.last_step)
					state_d = esbcd_pkg::ST_YEAR;
			end
			esbcd_pkg::ST_YEAR: begin
				if (status.year_end)
					state_d = esbcd_pkg::ST_MONTH;
			end
			esbcd_pkg::ST_MONTH: begin
				if (status.month_end)
					state_d = esbcd_pkg::ST_DONE;
			end
			esbcd_pkg::ST_DONE: begin
				if (!status.out_busy)
					state_d = esbcd_pkg::ST_IDLE;
			end
			default: state_d = esbcd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = esbcd_pkg::CMD_NONE;
		case (state_q)
			esbcd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					cmd = esbcd_pkg::CMD_LOAD;
			end
			esbcd_pkg::ST_DAY:   cmd = esbcd_pkg::CMD_DAY;
			esbcd_pkg::ST_HOUR:  cmd = esbcd_pkg::CMD_HOUR;
			esbcd_pkg::ST_MIN:   cmd = esbcd_pkg::CMD_MIN;
			esbcd_pkg::ST_YEAR:  cmd = esbcd_pkg::CMD_YEAR;
			esbcd_pkg::ST_MONTH: cmd = esbcd_pkg::CMD_MONTH;
			esbcd_pkg::ST_DONE: begin
				// hold until the output register can take the beat
				if (!status.out_busy)
					cmd = esbcd_pkg::CMD_PUBLISH;
			end
			default: cmd = esbcd_pkg::CMD_NONE;
		endcase
	end

endmodule

/* rtl/esbcd_dp.sv */
`include "assert_macros.svh"

module esbcd_dp #(
	parameter int unsigned EPOCH_YEAR = 1978
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  esbcd_pkg::cmd_t                cmd,
	output esbcd_pkg::status_t             status,
	input  logic [esbcd_pkg::SECS_W-1:0]   seconds_count,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [6:0]                     seconds_bcd,
	output logic [6:0]                     minutes_bcd,
	output logic [5:0]                     hours_bcd,
	output logic [5:0]                     date_bcd,
	output logic [7:0]                     month_century_bcd,
	output logic [7:0]                     year_bcd
);

	localparam int unsigned EpochYy = EPOCH_YEAR % 100;
	localparam logic [esbcd_pkg::YEAR_W-1:0] YEAR_INIT = esbcd_pkg::YEAR_W'(EPOCH_YEAR);
	localparam logic [1:0] M4_INIT   = 2'(EPOCH_YEAR % 4);
	localparam logic [6:0] M100_INIT = 7'(EpochYy);
	localparam logic [8:0] M400_INIT = 9'(EPOCH_YEAR % 400);
	localparam logic [3:0] YY_TENS_INIT = 4'(EpochYy / 10);
	localparam logic [3:0] YY_ONES_INIT = 4'(EpochYy % 10);

	logic [esbcd_pkg::SECS_W-1:0]   rem_q;
	logic [esbcd_pkg::CNT_W-1:0]    cnt_q;
	logic [esbcd_pkg::DAYS_W-1:0]   days_q;
	logic [4:0]                     hour_q;
	logic [5:0]                     min_q;
	logic [esbcd_pkg::YEAR_W-1:0]   year_q;
	logic [1:0]                     m4_q;
	logic [6:0]                     m100_q;
	logic [8:0]                     m400_q;
	logic [3:0]                     yy_tens_q;
	logic [3:0]                     yy_ones_q;
	logic [3:0]                     month_q;
	logic                           out_valid_q;

	logic [50:0]                    day_prod;
	logic [25:0]                    hour_prod;
	logic [19:0]                    min_prod;
	logic [esbcd_pkg::SECS_W-1:0]   back_quo;
	logic [esbcd_pkg::SECS_W-1:0]   back_base;
	logic [esbcd_pkg::SECS_W-1:0]   back_prod;
	logic [esbcd_pkg::SECS_W-1:0]   rem_sub;
	logic                           leap;
	logic [8:0]                     year_len;
	logic [4:0]                     mon_len;
	logic                           year_end;
	logic                           month_end;
	logic [6:0]                     date_bin;
	logic [7:0]                     sec_bcd8;
	logic [7:0]                     min_bcd8;
	logic [7:0]                     hour_bcd8;
	logic [7:0]                     date_bcd8;
	logic [7:0]                     mon_bcd8;

	// reciprocal multiplies; the low bits of each divisor come off as a shift first
	assign day_prod  = {26'd0, rem_q[31:7]} * esbcd_pkg::DAY_RECIP;
	assign hour_prod = {13'd0, rem_q[16:4]} * esbcd_pkg::HOUR_RECIP;
	assign min_prod  = {10'd0, rem_q[11:2]} * esbcd_pkg::MIN_RECIP;

	// multiply the fresh quotient back and take it off the remainder
	always_comb begin
		case (cmd)
			esbcd_pkg::CMD_DAY: begin
				back_quo  = {16'd0, days_q};
				back_base = esbcd_pkg::DAY_SECS;
			end
			esbcd_pkg::CMD_HOUR: begin
				back_quo  = {27'd0, hour_q};
				back_base = esbcd_pkg::HOUR_SECS;
			end
			default: begin
				back_quo  = {26'd0, min_q};
				back_base = esbcd_pkg::MIN_SECS;
			end
		endcase
	end

	assign back_prod = back_quo * back_base;
	assign rem_sub   = rem_q - back_prod;

	assign leap     = (m4_q == 2'd0) && ((m100_q != 7'd0) || (m400_q == 9'd0));
	assign year_len = leap ? 9'd366 : 9'd365;
	assign mon_len  = esbcd_pkg::month_days(month_q) +
		5'((month_q == esbcd_pkg::FEB) && leap);
	assign year_end  = days_q < {{(esbcd_pkg::DAYS_W - 9){1'b0}}, year_len};
	assign month_end = (month_q == esbcd_pkg::LAST_MONTH) ||
		(days_q < {{(esbcd_pkg::DAYS_W - 5){1'b0}}, mon_len});

	assign status.last_step = (cnt_q == esbcd_pkg::STEP_BACK);
	assign status.year_end  = year_end;
	assign status.month_end = month_end;
	assign status.out_busy  = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		case (cmd)
			esbcd_pkg::CMD_LOAD: begin
				rem_q     <= seconds_count;
				cnt_q     <= esbcd_pkg::STEP_QUO;
				year_q    <= YEAR_INIT;
				m4_q      <= M4_INIT;
				m100_q    <= M100_INIT;
				m400_q    <= M400_INIT;
				yy_tens_q <= YY_TENS_INIT;
				yy_ones_q <= YY_ONES_INIT;
			end
			esbcd_pkg::CMD_DAY: begin
				if (cnt_q == esbcd_pkg::STEP_QUO) begin
					days_q <= day_prod[50:35];
					cnt_q  <= esbcd_pkg::STEP_BACK;
				end else begin
					rem_q <= rem_sub;
					cnt_q <= esbcd_pkg::STEP_QUO;
				end
			end
			esbcd_pkg::CMD_HOUR: begin
				if (cnt_q == esbcd_pkg::STEP_QUO) begin
					hour_q <= hour_prod[25:21];
					cnt_q  <= esbcd_pkg::STEP_BACK;
				end else begin
					rem_q <= rem_sub;
					cnt_q <= esbcd_pkg::STEP_QUO;
				end
			end
			esbcd_pkg::CMD_MIN: begin
				// the remainder left here is the seconds
				if (cnt_q == esbcd_pkg::STEP_QUO) begin
					min_q <= min_prod[19:14];
					cnt_q <= esbcd_pkg::STEP_BACK;
				end else begin
					rem_q <= rem_sub;
				end
			end
			esbcd_pkg::CMD_YEAR: begin
				if (!year_end) begin
					days_q <= days_q - {{(esbcd_pkg::DAYS_W - 9){1'b0}}, year_len};
					year_q <= year_q + 1'b1;
					m4_q   <= m4_q + 1'b1;
					m100_q <= (m100_q == 7'd99) ? 7'd0 : m100_q + 1'b1;
					m400_q <= (m400_q == 9'd399) ? 9'd0 : m400_q + 1'b1;
					// advance the two-digit BCD year
					if (yy_ones_q == 4'd9) begin
						yy_ones_q <= 4'd0;
						yy_tens_q <= (yy_tens_q == 4'd9) ? 4'd0 : yy_tens_q + 1'b1;
					end else begin
						yy_ones_q <= yy_ones_q + 1'b1;
					end
				end
			end
			esbcd_pkg::CMD_MONTH: begin
				if (!month_end)
					days_q <= days_q - {{(esbcd_pkg::DAYS_W - 5){1'b0}}, mon_len};
			end
			default: begin
			end
		endcase
	end

	// month counter is reset so its range holds at all times
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			month_q <= 4'd1;
		end else if (cmd == esbcd_pkg::CMD_LOAD) begin
			month_q <= 4'd1;
		end else if (cmd == esbcd_pkg::CMD_MONTH && !month_end) begin
			month_q <= month_q + 1'b1;
		end
	end

	assign date_bin  = {2'b00, days_q[4:0]} + 7'd1;
	assign sec_bcd8  = esbcd_pkg::to_bcd({1'b0, rem_q[5:0]});
	assign min_bcd8  = esbcd_pkg::to_bcd({1'b0, min_q});
	assign hour_bcd8 = esbcd_pkg::to_bcd({2'b00, hour_q});
	assign date_bcd8 = esbcd_pkg::to_bcd(date_bin);
	assign mon_bcd8  = esbcd_pkg::to_bcd({3'b000, month_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd == esbcd_pkg::CMD_PUBLISH) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == esbcd_pkg::CMD_PUBLISH) begin
			seconds_bcd       <= sec_bcd8[6:0];
			minutes_bcd       <= min_bcd8[6:0];
			hours_bcd         <= hour_bcd8[5:0];
			date_bcd          <= date_bcd8[5:0];
			month_century_bcd <= {year_q >= esbcd_pkg::CENTURY_YEAR, 2'b00, mon_bcd8[4:0]};
			year_bcd          <= {yy_tens_q, yy_ones_q};
		end
	end

	assign out_valid = out_valid_q;

	`AST_SAME(a_month_range, 1'b1, month_q >= 4'd1 && month_q <= esbcd_pkg::LAST_MONTH, "month out of range")
	`AST_SAME(a_publish_free, cmd == esbcd_pkg::CMD_PUBLISH, !(out_valid_q && !out_ready), "publish over a held beat")
	`AST_NEXT(a_publish_valid, cmd == esbcd_pkg::CMD_PUBLISH, out_valid_q, "published beat not valid")
	`AST_SAME(a_date_range, cmd == esbcd_pkg::CMD_PUBLISH, days_q < 16'd31, "day of month out of range")

endmodule

/* rtl/epoch_seconds_to_bcd_calendar.sv */
// Channel   Signals                                      Direction
// input     in_valid, in_ready, seconds_count            sink
// output    out_valid, out_ready, seconds_bcd ...        source
//           minutes_bcd, hours_bcd, date_bcd,
//           month_century_bcd, year_bcd
//
// One item at a time: the item is accepted, the count is split into days,
// hours, minutes and seconds (a reciprocal multiply and a multiply-back for each
// of days, hours and minutes), then the datapath walks the days one year per step
// and then one month per step, and the result is published.
// A finished result waits in the output register; a new item is taken while
// it waits, and only the publish step stalls on out_ready.
// Reset clears the controller and the output valid flag.
module epoch_seconds_to_bcd_calendar #(
	parameter int unsigned EPOCH_YEAR = 1978
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [esbcd_pkg::SECS_W-1:0] seconds_count,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [6:0]                   seconds_bcd,
	output logic [6:0]                   minutes_bcd,
	output logic [5:0]                   hours_bcd,
	output logic [5:0]                   date_bcd,
	output logic [7:0]                   month_century_bcd,
	output logic [7:0]                   year_bcd
);

	esbcd_pkg::cmd_t    cmd;
	esbcd_pkg::status_t status;

	esbcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	esbcd_dp #(
		.EPOCH_YEAR (EPOCH_YEAR)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.seconds_count     (seconds_count),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.seconds_bcd       (seconds_bcd),
		.minutes_bcd       (minutes_bcd),
		.hours_bcd         (hours_bcd),
		.date_bcd          (date_bcd),
		.month_century_bcd (month_century_bcd),
		.year_bcd          (year_bcd)
	);

endmodule

/* dv/tb.sv */
// Expected calendar fields for one accepted seconds count
typedef struct {
	logic [31:0] secs;
	logic [6:0]  sec;
	logic [6:0]  min;
	logic [5:0]  hour;
	logic [5:0]  date;
	logic [7:0]  month;
	logic [7:0]  year;
} cal_t;

function automatic bit leap_year(int unsigned y);
	return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
endfunction

function automatic int unsigned year_length(int unsigned y);
	return leap_year(y) ? 366 : 365;
endfunction

function automatic int unsigned month_length(int unsigned y, int unsigned m);
	int unsigned len;
	case (m)
		2:       len = leap_year(y) ? 29 : 28;
		4, 6, 9, 11: len = 30;
		default: len = 31;
	endcase
	return len;
endfunction

class calendar_board;
	localparam int unsigned EPOCH    = 1978;
	localparam int unsigned DAY_S    = 86400;
	localparam int unsigned HOUR_S   = 3600;
	localparam int unsigned CENTURY  = 2100;
	localparam logic [7:0]  CENT_BIT = 8'h80;

	cal_t        dates_due[$];
	int unsigned errors;

	function new();
		errors = 0;
	endfunction

	static function logic [7:0] bcd(int unsigned v);
		return {4'((v / 10) % 10), 4'(v % 10)};
	endfunction

	function cal_t calendar_of(logic [31:0] secs);
		cal_t        r;
		int unsigned days;
		int unsigned rem;
		int unsigned yr;
		int unsigned mo;
		days   = secs / DAY_S;
		rem    = secs % DAY_S;
		r.secs = secs;
		r.hour = 6'(bcd(rem / HOUR_S));
		rem    = rem % HOUR_S;
		r.min  = 7'(bcd(rem / 60));
		r.sec  = 7'(bcd(rem % 60));
		yr = EPOCH;
		while (days >= year_length(yr)) begin
			days -= year_length(yr);
			yr++;
		end
		mo = 1;
		while (mo < 12 && days >= month_length(yr, mo)) begin
			days -= month_length(yr, mo);
			mo++;
		end
		r.date  = 6'(bcd(days + 1));
		r.month = bcd(mo) | ((yr >= CENTURY) ? CENT_BIT : 8'h00);
		r.year  = bcd(yr % 100);
		return r;
	endfunction

	function void note_input(logic [31:0] secs);
		dates_due.push_back(calendar_of(secs));
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task compare_field(string name, logic [31:0] secs, int unsigned got, int unsigned want);
		if (got != want)
			report($sformatf("%s got %02h want %02h (count %08h)", name, got, want, secs));
	endtask

	task check_result(cal_t got);
		cal_t want;
		if (dates_due.size() == 0) begin
			report($sformatf("unexpected beat %02h:%02h:%02h %02h/%02h/%02h",
				got.hour, got.min, got.sec, got.date, got.month, got.year));
		end else begin
			want = dates_due.pop_front();
			compare_field("seconds_bcd", want.secs, got.sec, want.sec);
			compare_field("minutes_bcd", want.secs, got.min, want.min);
			compare_field("hours_bcd", want.secs, got.hour, want.hour);
			compare_field("date_bcd", want.secs, got.date, want.date);
			compare_field("month_century_bcd", want.secs, got.month, want.month);
			compare_field("year_bcd", want.secs, got.year, want.year);
		end
	endtask
endclass

module tb;

	localparam int unsigned EPOCH_YEAR  = 1978;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned LONG_HOLD   = 600;
	localparam int unsigned TAIL_CYCLES = 200;
	localparam int unsigned RAND_ITEMS  = 900;
	localparam int unsigned HOLD_AT     = 250;
	localparam int unsigned DRAIN_AT    = 550;
	localparam int unsigned CALM_FROM   = 800;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [esbcd_pkg::SECS_W-1:0] seconds_count;
	logic                         out_valid;
	logic                         out_ready;
	logic [6:0]                   seconds_bcd;
	logic [6:0]                   minutes_bcd;
	logic [5:0]                   hours_bcd;
	logic [5:0]                   date_bcd;
	logic [7:0]                   month_century_bcd;
	logic [7:0]                   year_bcd;

	calendar_board board;
	cal_t          seen;
	int unsigned   stall_cycles;
	bit            calm;
	bit            hold_req;

	epoch_seconds_to_bcd_calendar dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.seconds_count     (seconds_count),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.seconds_bcd       (seconds_bcd),
		.minutes_bcd       (minutes_bcd),
		.hours_bcd         (hours_bcd),
		.date_bcd          (date_bcd),
		.month_century_bcd (month_century_bcd),
		.year_bcd          (year_bcd)
	);

	always #1 clk = ~clk;

	// seconds from the epoch start to the given wall-clock time, wrapped to 32 bits
	function automatic logic [31:0] secs_at(int unsigned y, int unsigned mo, int unsigned d,
		int unsigned h, int unsigned mi, int unsigned s);
		longint unsigned days;
		days = 0;
		for (int unsigned yy = EPOCH_YEAR; yy < y; yy++)
			days += year_length(yy);
		for (int unsigned mm = 1; mm < mo; mm++)
			days += month_length(y, mm);
		days += d - 1;
		return 32'(days * 86400 + h * 3600 + mi * 60 + s);
	endfunction

	function automatic logic [31:0] random_count();
		int unsigned y;
		int unsigned mo;
		logic [31:0] v;
		y  = $urandom_range(1978, 2113);
		mo = $urandom_range(1, 12);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom;
			4, 5, 6: v = secs_at(y, mo, $urandom_range(1, month_length(y, mo)),
				$urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
			// land a few seconds either side of a month start
			7, 8: v = secs_at(y, mo, 1, 0, 0, 0) + 32'($urandom_range(0, 6)) - 32'd3;
			default: v = $urandom_range(0, 3 * 86400);
		endcase
		return v;
	endfunction

	task automatic offer(input logic [31:0] secs);
		in_valid      <= 1'b1;
		seconds_count <= secs;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic pause_input(input int unsigned n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.dates_due.size() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_input(seconds_count);
			if (out_valid && out_ready) begin
				seen.sec   = seconds_bcd;
				seen.min   = minutes_bcd;
				seen.hour  = hours_bcd;
				seen.date  = date_bcd;
				seen.month = month_century_bcd;
				seen.year  = year_bcd;
				board.check_result(seen);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	// receiver: short random stalls, one long hold-off on request, none once calm
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	initial begin
		logic [31:0] directed[$];
		board         = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		seconds_count = '0;
		out_ready     = 1'b0;
		stall_cycles  = 0;
		calm          = 1'b0;
		hold_req      = 1'b0;

		directed.push_back(32'd0);
		directed.push_back(32'hFFFF_FFFF);
		directed.push_back(32'd86399);
		directed.push_back(secs_at(1978, 12, 31, 23, 59, 59));
		directed.push_back(secs_at(1979, 1, 1, 0, 0, 0));
		directed.push_back(secs_at(1980, 2, 29, 12, 34, 56));
		directed.push_back(secs_at(1980, 3, 1, 9, 9, 9));
		directed.push_back(secs_at(1999, 12, 31, 23, 59, 59));
		directed.push_back(secs_at(2000, 1, 1, 0, 0, 0));
		directed.push_back(secs_at(2000, 2, 29, 10, 10, 10));
		directed.push_back(secs_at(2000, 12, 31, 19, 29, 39));
		directed.push_back(secs_at(2001, 2, 28, 23, 59, 59));
		directed.push_back(secs_at(2001, 3, 1, 0, 0, 0));
		directed.push_back(secs_at(2038, 1, 19, 3, 14, 7));
		directed.push_back(secs_at(2099, 12, 31, 23, 59, 59));
		directed.push_back(secs_at(2100, 1, 1, 0, 0, 0));
		directed.push_back(secs_at(2100, 2, 28, 23, 59, 59));
		directed.push_back(secs_at(2100, 3, 1, 0, 0, 0));
		directed.push_back(secs_at(2104, 2, 29, 20, 0, 1));
		directed.push_back(secs_at(2113, 12, 31, 23, 59, 59));
		directed.push_back(secs_at(2114, 1, 1, 0, 0, 0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			offer(directed[i]);
			if ($urandom_range(0, 2) == 0)
				pause_input($urandom_range(1, 12));
		end

		for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
			if (n == HOLD_AT)
				hold_req = 1'b1;
			if (n == DRAIN_AT)
				wait_drained();
			if (n == CALM_FROM)
				calm = 1'b1;
			offer(random_count());
			if (!calm && $urandom_range(0, 3) == 0)
				pause_input($urandom_range(1, 12));
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.dates_due.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule
